[rtl/gaussian_2d_residual_jacobian_defines.svh]
// Assertion macros shared by the RTL of the Gaussian residual and Jacobian block.
`ifndef GAUSSIAN_2D_RESIDUAL_JACOBIAN_DEFINES_SVH
`define GAUSSIAN_2D_RESIDUAL_JACOBIAN_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define G2RJ_ASSERT_SAME(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define G2RJ_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/g2rj_pkg.sv]
package g2rj_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_AMPLITUDE,
        REG_SIGMA,
        REG_BACKGROUND,
        REG_FIT_MASK,
        REG_WINDOW_SIZE
    } reg_idx_t;

    localparam logic [15:0] SIGMA_MIN    = 16'd256;
    localparam logic [16:0] LOG2E_Q16    = 17'd94548;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [61:0] HALF_Q30     = 62'd536870912;
    localparam logic [8:0]  EXP_N_LIMIT  = 9'd20;
    localparam logic [31:0] C_TERM       = 32'h0001_0000;
    localparam logic [31:0] POS_LIMIT    = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;

    // 2^(-2^-k) in Q0.30 for k = 1..16.
    localparam logic [29:0] POW2_NEG_FRAC [16] = '{
        30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
        30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
        30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135,
        30'd1073650976, 30'd1073696399, 30'd1073719111, 30'd1073730468
    };

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        amplitude;
        logic [15:0]        sigma;
        logic [15:0]        background;
        logic [4:0]         fit_mask;
        logic [5:0]         window_size;
    } cfg_t;

    // Side data carried through the exponent divider.
    typedef struct packed {
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [15:0]        pixel;
        logic [31:0]        s2;
        logic [15:0]        sg;
    } e_pay_t;

    // Side data carried through the exponential unit.
    typedef struct packed {
        e_pay_t      base;
        logic [23:0] e;
    } x_pay_t;

    // Side data carried through the sigma-term divider.
    typedef struct packed {
        logic               g_zero;
        logic [16:0]        g;
        logic signed [31:0] residual;
    } s_pay_t;

    typedef struct packed {
        logic signed [31:0]    residual;
        logic [4:0][31:0]      jac;
        logic                  saturated;
    } out_t;

endpackage

[rtl/gaussian_2d_residual_jacobian.sv]
// Throughput: one pixel per cycle while in_stall is low; the 24-step
// exponent divider, the 16-step exponential unit and three 32-step dividers
// are all fully pipelined. A two-entry output buffer lets the pipeline hold
// while a result waits. Reset (rst_n, asynchronous, active low) clears all
// valid bits and loads the configuration registers with their default values.
`include "gaussian_2d_residual_jacobian_defines.svh"

module gaussian_2d_residual_jacobian
    import g2rj_pkg::*;
#(
    parameter int MAX_WINDOW = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         row_index,
    input  logic [4:0]         col_index,
    input  logic [15:0]        pixel_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] residual,
    output logic signed [31:0] jac_first,
    output logic signed [31:0] jac_second,
    output logic signed [31:0] jac_third,
    output logic signed [31:0] jac_fourth,
    output logic signed [31:0] jac_fifth,
    output logic               saturated
);

    cfg_t cfg;
    logic en;
    logic accept;

    g2rj_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Offsets from the window center.
    logic [6:0]         ws_clamp;
    logic [5:0]         half;
    logic signed [6:0]  row_off;
    logic signed [6:0]  col_off;
    logic signed [17:0] dx_next;
    logic signed [17:0] dy_next;

    always_comb
    begin
        if (cfg.window_size == 6'd0)
            ws_clamp = 7'd1;
        else if ({1'b0, cfg.window_size} > 7'(MAX_WINDOW))
            ws_clamp = 7'(MAX_WINDOW);
        else
            ws_clamp = {1'b0, cfg.window_size};
    end

    assign half    = ws_clamp[6:1];
    assign row_off = $signed({2'b00, row_index}) - $signed({1'b0, half});
    assign col_off = $signed({2'b00, col_index}) - $signed({1'b0, half});
    assign dx_next = $signed({{3{row_off[6]}}, row_off, 8'd0})
                   - $signed({{2{cfg.center_x[15]}}, cfg.center_x});
    assign dy_next = $signed({{3{col_off[6]}}, col_off, 8'd0})
                   - $signed({{2{cfg.center_y[15]}}, cfg.center_y});

    assign accept = in_valid && !in_stall;

    // Stage 0: offsets.
    logic               s0_vld_reg;
    logic signed [17:0] s0_dx_reg;
    logic signed [17:0] s0_dy_reg;
    logic [15:0]        s0_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dx_reg  <= dx_next;
            s0_dy_reg  <= dy_next;
            s0_pix_reg <= pixel_value;
        end
    end

    // Stage 1: squared radius and squared sigma.
    logic signed [35:0] sq_x;
    logic signed [35:0] sq_y;
    logic [15:0]        sg_clamp;
    logic               s1_vld_reg;
    logic [31:0]        s1_r2_reg;
    e_pay_t             s1_pay_reg;

    assign sq_x     = 36'(s0_dx_reg) * 36'(s0_dx_reg);
    assign sq_y     = 36'(s0_dy_reg) * 36'(s0_dy_reg);
    assign sg_clamp = (cfg.sigma < SIGMA_MIN) ? SIGMA_MIN : cfg.sigma;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r2_reg        <= sq_x[31:0] + sq_y[31:0];
            s1_pay_reg.dx    <= s0_dx_reg;
            s1_pay_reg.dy    <= s0_dy_reg;
            s1_pay_reg.pixel <= s0_pix_reg;
            s1_pay_reg.s2    <= 32'(sg_clamp) * 32'(sg_clamp);
            s1_pay_reg.sg    <= sg_clamp;
        end
    end

    // Exponent E = round(r2 * 2^24 / (2 * s2)).
    logic        de_vld;
    logic [23:0] de_q;
    logic        de_ovf;
    e_pay_t      de_pay;

    g2rj_div #(
        .NW (57),
        .DW (33),
        .QW (24),
        .PW ($bits(e_pay_t))
    ) u_div_e (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s1_vld_reg),
        .num     ({1'b0, s1_r2_reg, 24'd0} + 57'(s1_pay_reg.s2)),
        .den     ({s1_pay_reg.s2, 1'b0}),
        .in_pay  (s1_pay_reg),
        .out_vld (de_vld),
        .quo     (de_q),
        .ovf     (de_ovf),
        .out_pay (de_pay)
    );

    // Gaussian value g = exp(-E).
    logic        ex_vld;
    logic [16:0] ex_g;
    x_pay_t      ex_pay;

    g2rj_exp #(
        .PW ($bits(x_pay_t))
    ) u_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (de_vld),
        .e       (de_q),
        .e_ovf   (de_ovf),
        .in_pay  ({de_pay, de_q}),
        .out_vld (ex_vld),
        .g       (ex_g),
        .out_pay (ex_pay)
    );

    // Stage A: amplitude times g, offset magnitudes.
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic               a_vld_reg;
    logic [31:0]        a_ag_reg;
    logic [15:0]        a_magx_reg;
    logic [15:0]        a_magy_reg;
    logic               a_negx_reg;
    logic               a_negy_reg;
    logic [23:0]        a_e_reg;
    logic [31:0]        a_s2_reg;
    logic [15:0]        a_sg_reg;
    logic [15:0]        a_pix_reg;
    logic [16:0]        a_g_reg;

    assign nx = -ex_pay.base.dx;
    assign ny = -ex_pay.base.dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= ex_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ag_reg   <= 32'(cfg.amplitude) * 32'(ex_g);
            a_magx_reg <= ex_pay.base.dx[17] ? nx[15:0] : ex_pay.base.dx[15:0];
            a_magy_reg <= ex_pay.base.dy[17] ? ny[15:0] : ex_pay.base.dy[15:0];
            a_negx_reg <= ex_pay.base.dx[17];
            a_negy_reg <= ex_pay.base.dy[17];
            a_e_reg    <= ex_pay.e;
            a_s2_reg   <= ex_pay.base.s2;
            a_sg_reg   <= ex_pay.base.sg;
            a_pix_reg  <= ex_pay.base.pixel;
            a_g_reg    <= ex_g;
        end
    end

    // Stage P: numerators of the three quotients and the residual.
    logic [32:0]        ag_rnd;
    logic signed [16:0] bg_diff;
    logic               p_vld_reg;
    logic [47:0]        p_pdx_reg;
    logic [47:0]        p_pdy_reg;
    logic [55:0]        p_pe_reg;
    logic [31:0]        p_s2_reg;
    logic [15:0]        p_sg_reg;
    logic               p_negx_reg;
    logic               p_negy_reg;
    s_pay_t             p_spay_reg;

    assign ag_rnd  = 33'(a_ag_reg) + 33'd128;
    assign bg_diff = $signed({1'b0, cfg.background}) - $signed({1'b0, a_pix_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_pdx_reg           <= 48'(a_ag_reg) * 48'(a_magx_reg);
            p_pdy_reg           <= 48'(a_ag_reg) * 48'(a_magy_reg);
            p_pe_reg            <= 56'(a_e_reg) * 56'(a_ag_reg);
            p_s2_reg            <= a_s2_reg;
            p_sg_reg            <= a_sg_reg;
            p_negx_reg          <= a_negx_reg;
            p_negy_reg          <= a_negy_reg;
            p_spay_reg.g_zero   <= (a_g_reg == 17'd0);
            p_spay_reg.g        <= a_g_reg;
            p_spay_reg.residual <= $signed({7'd0, ag_rnd[32:8]})
                                 + $signed({{7{bg_diff[16]}}, bg_diff, 8'd0});
        end
    end

    // Center and sigma derivatives.
    logic        dx_vld;
    logic [31:0] dx_q;
    logic        dx_ovf;
    logic        dx_neg;
    logic        dy_vld;
    logic [31:0] dy_q;
    logic        dy_ovf;
    logic        dy_neg;
    logic        ds_vld;
    logic [31:0] ds_q;
    logic        ds_ovf;
    s_pay_t      ds_pay;

    g2rj_div #(
        .NW (64),
        .DW (32),
        .QW (32),
        .PW (1)
    ) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (p_vld_reg),
        .num     ({p_pdx_reg, 16'd0} + 64'(p_s2_reg[31:1])),
        .den     (p_s2_reg),
        .in_pay  (p_negx_reg),
        .out_vld (dx_vld),
        .quo     (dx_q),
        .ovf     (dx_ovf),
        .out_pay (dx_neg)
    );

    g2rj_div #(
        .NW (64),
        .DW (32),
        .QW (32),
        .PW (1)
    ) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (p_vld_reg),
        .num     ({p_pdy_reg, 16'd0} + 64'(p_s2_reg[31:1])),
        .den     (p_s2_reg),
        .in_pay  (p_negy_reg),
        .out_vld (dy_vld),
        .quo     (dy_q),
        .ovf     (dy_ovf),
        .out_pay (dy_neg)
    );

    g2rj_div #(
        .NW (57),
        .DW (19),
        .QW (32),
        .PW ($bits(s_pay_t))
    ) u_div_s (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (p_vld_reg),
        .num     (57'(p_pe_reg) + 57'({p_sg_reg, 2'b00})),
        .den     ({p_sg_reg, 3'b000}),
        .in_pay  (p_spay_reg),
        .out_vld (ds_vld),
        .quo     (ds_q),
        .ovf     (ds_ovf),
        .out_pay (ds_pay)
    );

    // Saturate the center and sigma derivative terms and pack the enabled terms in order.
    logic [4:0][31:0] term;
    logic [4:0]       clip;
    out_t             res;
    logic [2:0]       slot;

    always_comb
    begin
        if (dx_neg)
        begin
            clip[0] = dx_ovf || (dx_q > NEG_LIMIT);
            term[0] = clip[0] ? NEG_LIMIT : (~dx_q + 32'd1);
        end
        else
        begin
            clip[0] = dx_ovf || dx_q[31];
            term[0] = clip[0] ? POS_LIMIT : dx_q;
        end

        if (dy_neg)
        begin
            clip[1] = dy_ovf || (dy_q > NEG_LIMIT);
            term[1] = clip[1] ? NEG_LIMIT : (~dy_q + 32'd1);
        end
        else
        begin
            clip[1] = dy_ovf || dy_q[31];
            term[1] = clip[1] ? POS_LIMIT : dy_q;
        end

        clip[2] = 1'b0;
        term[2] = 32'(ds_pay.g);

        if (ds_pay.g_zero)
        begin
            clip[3] = 1'b0;
            term[3] = '0;
        end
        else
        begin
            clip[3] = ds_ovf || ds_q[31];
            term[3] = clip[3] ? POS_LIMIT : ds_q;
        end

        clip[4] = 1'b0;
        term[4] = C_TERM;

        res.residual  = ds_pay.residual;
        res.jac       = '0;
        res.saturated = 1'b0;
        slot          = '0;
        for (int j = 0; j < 5; j++)
        begin
            if (cfg.fit_mask[j])
            begin
                res.jac[slot] = term[j];
                res.saturated = res.saturated | clip[j];
                slot          = slot + 3'd1;
            end
        end
    end

    // Output register with a skid entry; the pipeline holds while the skid is full.
    logic out_vld_reg;
    logic skid_vld_reg;
    out_t out_reg;
    out_t skid_reg;
    logic out_take;

    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;
    assign out_take = out_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_take)
                skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_take)
            out_vld_reg <= dx_vld;
        else if (dx_vld)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (!out_vld_reg || out_take)
            out_reg <= res;
        else
            skid_reg <= res;
    end

    assign out_valid  = out_vld_reg;
    assign residual   = out_reg.residual;
    assign jac_first  = out_reg.jac[0];
    assign jac_second = out_reg.jac[1];
    assign jac_third  = out_reg.jac[2];
    assign jac_fourth = out_reg.jac[3];
    assign jac_fifth  = out_reg.jac[4];
    assign saturated  = out_reg.saturated;

    // The three parallel dividers must stay in lockstep.
    `G2RJ_ASSERT_SAME(a_div_lockstep, 1'b1, (dx_vld == dy_vld) && (dx_vld == ds_vld), "divider valids disagree")
    // The skid entry is only occupied behind a waiting result.
    `G2RJ_ASSERT_SAME(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid full with empty output")
    // A held pipeline keeps its last stage unchanged.
    `G2RJ_ASSERT_NEXT(a_hold_stable, !en, $stable(dx_vld) && $stable(dx_q) && $stable(ds_q), "pipeline moved while held")

endmodule

[rtl/g2rj_cfg.sv]
module g2rj_cfg
    import g2rj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes on the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.amplitude   <= '0;
            cfg_reg.sigma       <= 16'd4096;
            cfg_reg.background  <= '0;
            cfg_reg.fit_mask    <= 5'd31;
            cfg_reg.window_size <= 6'd7;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_CENTER_X:    cfg_reg.center_x    <= pwdata[15:0];
                REG_CENTER_Y:    cfg_reg.center_y    <= pwdata[15:0];
                REG_AMPLITUDE:   cfg_reg.amplitude   <= pwdata[15:0];
                REG_SIGMA:       cfg_reg.sigma       <= pwdata[15:0];
                REG_BACKGROUND:  cfg_reg.background  <= pwdata[15:0];
                REG_FIT_MASK:    cfg_reg.fit_mask    <= pwdata[4:0];
                REG_WINDOW_SIZE: cfg_reg.window_size <= pwdata[5:0];
                default:         ;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:    prdata = {16'd0, cfg_reg.center_x};
            REG_CENTER_Y:    prdata = {16'd0, cfg_reg.center_y};
            REG_AMPLITUDE:   prdata = {16'd0, cfg_reg.amplitude};
            REG_SIGMA:       prdata = {16'd0, cfg_reg.sigma};
            REG_BACKGROUND:  prdata = {16'd0, cfg_reg.background};
            REG_FIT_MASK:    prdata = {27'd0, cfg_reg.fit_mask};
            REG_WINDOW_SIZE: prdata = {26'd0, cfg_reg.window_size};
            default:         prdata = '0;
        endcase
    end

endmodule

[rtl/g2rj_div.sv]
module g2rj_div
    import g2rj_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] in_pay,
    output logic          out_vld,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [PW-1:0] out_pay
);

    localparam int HW = NW - QW;

    logic          vld_reg [0:QW];
    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic [PW-1:0] pay_reg [0:QW];

    // Entry stage: a quotient that needs more than QW bits is flagged here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num[NW-1:QW]);
            ovf_reg[0] <= num[NW-1:QW] >= HW'(den);
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            pay_reg[0] <= in_pay;
        end
    end

    // One restoring step per stage, one quotient bit each.
    for (genvar i = 1; i <= QW; i++)
    begin : g_step
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        assign trial    = {rem_reg[i-1], low_reg[i-1][QW-1]};
        assign diff     = trial - {1'b0, den_reg[i-1]};
        assign ge       = trial >= {1'b0, den_reg[i-1]};
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= {low_reg[i-1][QW-2:0], 1'b0};
                quo_reg[i] <= {quo_reg[i-1][QW-2:0], ge};
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    assign out_vld = vld_reg[QW];
    assign quo     = quo_reg[QW];
    assign ovf     = ovf_reg[QW];
    assign out_pay = pay_reg[QW];

endmodule

[rtl/g2rj_exp.sv]
module g2rj_exp
    import g2rj_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [23:0]   e,
    input  logic          e_ovf,
    input  logic [PW-1:0] in_pay,
    output logic          out_vld,
    output logic [16:0]   g,
    output logic [PW-1:0] out_pay
);

    logic          vld_reg  [0:16];
    logic          zero_reg [0:16];
    logic [4:0]    n_reg    [0:16];
    logic [15:0]   f_reg    [0:16];
    logic [30:0]   acc_reg  [0:16];
    logic [PW-1:0] pay_reg  [0:16];

    logic          g_vld_reg;
    logic [16:0]   g_reg;
    logic [PW-1:0] g_pay_reg;

    logic [41:0]   t_full;
    logic [24:0]   t;

    // Exponent scaled to base 2, rounded half up.
    assign t_full = 42'(e) * 42'(LOG2E_Q16) + 42'd32768;
    assign t      = t_full[40:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= e_ovf || (t[24:16] >= EXP_N_LIMIT);
            n_reg[0]    <= t[20:16];
            f_reg[0]    <= t[15:0];
            acc_reg[0]  <= ONE_Q30;
            pay_reg[0]  <= in_pay;
        end
    end

    // Fraction applied one bit per stage, MSB first.
    for (genvar i = 1; i <= 16; i++)
    begin : g_frac
        logic [61:0] prod;
        logic [30:0] acc_next;

        assign prod     = 62'(acc_reg[i-1]) * 62'(POW2_NEG_FRAC[i-1]) + HALF_Q30;
        assign acc_next = f_reg[i-1][16-i] ? prod[60:30] : acc_reg[i-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i] <= zero_reg[i-1];
                n_reg[i]    <= n_reg[i-1];
                f_reg[i]    <= f_reg[i-1];
                acc_reg[i]  <= acc_next;
                pay_reg[i]  <= pay_reg[i-1];
            end
        end
    end

    // Integer part: rounded right shift down to Q1.16.
    logic [5:0]  shamt;
    logic [33:0] rnd_sum;
    logic [33:0] shifted;

    assign shamt   = 6'd14 + {1'b0, n_reg[16]};
    assign rnd_sum = 34'(acc_reg[16]) + (34'd1 << (shamt - 6'd1));
    assign shifted = rnd_sum >> shamt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (en)
            g_vld_reg <= vld_reg[16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg     <= zero_reg[16] ? 17'd0 : shifted[16:0];
            g_pay_reg <= pay_reg[16];
        end
    end

    assign out_vld = g_vld_reg;
    assign g       = g_reg;
    assign out_pay = g_pay_reg;

endmodule
